@@ hdl/rhc_pkg.sv @@
// shared types and constants for the rgb/hsv pixel converter
// no dependencies
package rhc_pkg;

  localparam int unsigned NUM_W = 22;
  localparam int unsigned DEN_W = 14;
  localparam int unsigned QUO_W = 8;
  localparam logic [DEN_W-1:0] CHAN_DEN = 14'd15300;

  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic       neg;
    max_sel_e   max_sel;
    logic       gray;
    logic       black;
  } side_t;

endpackage

@@ hdl/rhc_front.sv @@
// front end: channel compare or sector decode, then divider operands
// depends on rhc_pkg
module rhc_front import rhc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             mode_i,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic [8:0]       hue_i,
  input  logic [7:0]       sat_i,
  input  logic [7:0]       val_i,
  output logic [NUM_W-1:0] num_o [3],
  output logic [DEN_W-1:0] den_o [3],
  output side_t            side_o
);

  side_t       side1_d, side1_q;
  logic [7:0]  delta_d, delta_q;
  logic [7:0]  adiff_d, adiff_q;
  logic [15:0] vs_d, vs_q;
  logic [5:0]  kr_d, kr_q, kg_d, kg_q, kb_d, kb_q;
  logic [NUM_W-1:0] num_d [3];
  logic [DEN_W-1:0] den_d [3];

  logic [7:0] mx, mn;
  logic [8:0] hc;
  logic [2:0] sector;
  logic [5:0] f, kx;
  logic [8:0] sdiff;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta_d = mx - mn;

    side1_d = '0;
    side1_d.mode  = mode_i;
    side1_d.red   = red_i;
    side1_d.green = green_i;
    side1_d.blue  = blue_i;
    side1_d.sat   = sat_i;
    side1_d.gray  = (delta_d == 8'd0);
    side1_d.black = (mx == 8'd0);

    if (mx == red_i) begin
      side1_d.max_sel = MAX_RED;
      sdiff = {1'b0, green_i} - {1'b0, blue_i};
    end else if (mx == green_i) begin
      side1_d.max_sel = MAX_GREEN;
      sdiff = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      side1_d.max_sel = MAX_BLUE;
      sdiff = {1'b0, red_i} - {1'b0, green_i};
    end
    side1_d.neg = sdiff[8];
    adiff_d = sdiff[8] ? 8'(-sdiff) : sdiff[7:0];

    hc = (hue_i >= 9'd360) ? 9'd0 : hue_i;
    side1_d.hue = mode_i ? hc : 9'd0;
    side1_d.val = mode_i ? val_i : mx;

    if (hc >= 9'd300) sector = 3'd5;
    else if (hc >= 9'd240) sector = 3'd4;
    else if (hc >= 9'd180) sector = 3'd3;
    else if (hc >= 9'd120) sector = 3'd2;
    else if (hc >= 9'd60) sector = 3'd1;
    else sector = 3'd0;
    f = 6'(hc - 9'd60 * {6'd0, sector});
    kx = sector[0] ? 6'd60 - f : f;

    kr_d = 6'd0;
    kg_d = 6'd0;
    kb_d = 6'd0;
    case (sector)
      3'd0: begin kr_d = 6'd60; kg_d = kx;    kb_d = 6'd0;  end
      3'd1: begin kr_d = kx;    kg_d = 6'd60; kb_d = 6'd0;  end
      3'd2: begin kr_d = 6'd0;  kg_d = 6'd60; kb_d = kx;    end
      3'd3: begin kr_d = 6'd0;  kg_d = kx;    kb_d = 6'd60; end
      3'd4: begin kr_d = kx;    kg_d = 6'd0;  kb_d = 6'd60; end
      default: begin kr_d = 6'd60; kg_d = 6'd0; kb_d = kx; end
    endcase
    vs_d = val_i * sat_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      delta_q <= delta_d;
      adiff_q <= adiff_d;
      vs_q    <= vs_d;
      kr_q    <= kr_d;
      kg_q    <= kg_d;
      kb_q    <= kb_d;
    end
  end

  always_comb begin
    if (side1_q.mode) begin
      num_d[0] = NUM_W'(vs_q) * NUM_W'(6'd60 - kr_q);
      num_d[1] = NUM_W'(vs_q) * NUM_W'(6'd60 - kg_q);
      num_d[2] = NUM_W'(vs_q) * NUM_W'(6'd60 - kb_q);
      den_d[0] = CHAN_DEN;
      den_d[1] = CHAN_DEN;
      den_d[2] = CHAN_DEN;
    end else begin
      num_d[0] = NUM_W'({delta_q, 8'd0}) - NUM_W'(delta_q);
      num_d[1] = NUM_W'({adiff_q, 6'd0}) - NUM_W'({adiff_q, 2'd0});
      num_d[2] = '0;
      den_d[0] = DEN_W'(side1_q.val);
      den_d[1] = DEN_W'(delta_q);
      den_d[2] = DEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side1_q;
      num_o  <= num_d;
      den_o  <= den_d;
    end
  end

endmodule

@@ hdl/rhc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on rhc_pkg
module rhc_div import rhc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             rem_nz_o
);

  logic [DEN_W-1:0] rem_q [QUO_W+1];
  logic [QUO_W-1:0] low_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];

  assign rem_q[0] = num_i[NUM_W-1:QUO_W];
  assign low_q[0] = num_i[QUO_W-1:0];
  assign quo_q[0] = '0;
  assign den_q[0] = den_i;

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;
    assign trial = {rem_q[i], low_q[i][QUO_W-1]};
    assign diff  = trial - {1'b0, den_q[i]};
    assign take  = (trial >= {1'b0, den_q[i]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low_q[i+1] <= {low_q[i][QUO_W-2:0], 1'b0};
        quo_q[i+1] <= {quo_q[i][QUO_W-2:0], take};
        den_q[i+1] <= den_q[i];
      end
    end
  end

  assign quo_o    = quo_q[QUO_W];
  assign rem_nz_o = (rem_q[QUO_W] != '0);

endmodule

@@ hdl/rgb_hsv_converter.sv @@
// rgb to hsv and hsv to rgb pixel converter, top level
// one pixel per cycle sustained while the output accepts results
// two front stages, eight divider stages (one quotient bit each), one output stage
// the pipeline stalls as a whole only while a result waits at the output
// reset clears the valid bits; data registers are not reset
module rgb_hsv_converter import rhc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // in_red, in_green, in_blue, in_hue, in_sat, in_val
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // out_red, out_green, out_blue, out_hue, out_sat, out_val
);

  localparam int unsigned DEPTH = 2 + QUO_W + 1;

  logic             en;
  logic [DEPTH-1:0] vld_q;
  logic [NUM_W-1:0] num [3];
  logic [DEN_W-1:0] den [3];
  logic [QUO_W-1:0] quo [3];
  logic [2:0]       rem_nz;
  side_t            side2;
  side_t            side_q [QUO_W];
  logic [55:0]      tdata_d, tdata_q;

  assign en = ~vld_q[DEPTH-1] | m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  rhc_front u_front (
    .clk_i    (clk_i),
    .en_i     (en),
    .mode_i   (s_axis_tuser),
    .red_i    (s_axis_tdata[7:0]),
    .green_i  (s_axis_tdata[15:8]),
    .blue_i   (s_axis_tdata[23:16]),
    .hue_i    (s_axis_tdata[32:24]),
    .sat_i    (s_axis_tdata[40:33]),
    .val_i    (s_axis_tdata[48:41]),
    .num_o    (num),
    .den_o    (den),
    .side_o   (side2)
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rhc_div u_div (
      .clk_i    (clk_i),
      .en_i     (en),
      .num_i    (num[l]),
      .den_i    (den[l]),
      .quo_o    (quo[l]),
      .rem_nz_o (rem_nz[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side2;
      for (int i = 1; i < QUO_W; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  side_t       sd;
  logic [7:0]  ch [3];
  logic [8:0]  hq;
  logic [9:0]  hoff;
  logic [9:0]  hsum;
  logic [8:0]  hue_out;
  logic [7:0]  sat_out;

  always_comb begin
    sd = side_q[QUO_W-1];
    for (int l = 0; l < 3; l++) begin
      ch[l] = sd.val - (quo[l] + {7'd0, rem_nz[l]});
    end
    hq = {1'b0, quo[1]} + ((sd.neg && rem_nz[1]) ? 9'd1 : 9'd0);
    case (sd.max_sel)
      MAX_GREEN: hoff = 10'd120;
      MAX_BLUE:  hoff = 10'd240;
      default:   hoff = 10'd0;
    endcase
    hsum = sd.neg ? hoff - {1'b0, hq} : hoff + {1'b0, hq};
    if (hsum[9]) hsum = hsum + 10'd360;
    hue_out = sd.gray ? 9'd0 : hsum[8:0];
    sat_out = sd.black ? 8'd0 : quo[0];
    if (sd.mode) begin
      tdata_d = {7'd0, sd.val, sd.sat, sd.hue, ch[2], ch[1], ch[0]};
    end else begin
      tdata_d = {7'd0, sd.val, sat_out, hue_out, sd.blue, sd.green, sd.red};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= tdata_d;
    end
  end

  assign m_axis_tvalid = vld_q[DEPTH-1];
  assign m_axis_tdata  = tdata_q;

endmodule

@@ tb/sv/rgb_hsv_converter_tb.sv @@
// testbench for the rgb/hsv pixel converter: directed table then random pixels,
// every result checked against a typed-in result or a behavioral color-space predictor
// depends on rhc_pkg and rgb_hsv_converter
module rgb_hsv_converter_tb;
  import rhc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_TO_HSV = 1'b0;
  localparam logic MODE_TO_RGB = 1'b1;
  localparam int unsigned N_RANDOM = 1030;
  localparam int unsigned WATCHDOG = 2000;
  localparam int unsigned LATENCY = 11;

  typedef struct packed {
    logic [7:0] val;
    logic [7:0] sat;
    logic [8:0] hue;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct {
    logic   mode;
    pixel_t pix;
    logic   known;
    pixel_t res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  pixel_t      pixel_queue[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  bit          timed_out = 1'b0;

  rgb_hsv_converter dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic pixel_t convert_pixel(logic mode, pixel_t p);
    pixel_t o;
    int mx, mn, dl, diff, off, hh, num, sector, f, kx;
    int k[3];
    o = p;
    if (mode == MODE_TO_HSV) begin
      mx = p.red; mn = p.red;
      if (p.green > mx) mx = p.green;
      if (p.blue > mx) mx = p.blue;
      if (p.green < mn) mn = p.green;
      if (p.blue < mn) mn = p.blue;
      dl = mx - mn;
      o.val = mx[7:0];
      o.sat = (mx == 0) ? 8'd0 : 8'((dl * 255) / mx);
      hh = 0;
      if (dl != 0) begin
        if (mx == p.red) begin
          diff = int'(p.green) - int'(p.blue); off = 0;
        end else if (mx == p.green) begin
          diff = int'(p.blue) - int'(p.red); off = 120;
        end else begin
          diff = int'(p.red) - int'(p.green); off = 240;
        end
        num = 60 * diff;
        hh = num / dl;
        if (num % dl != 0 && num < 0) hh -= 1;
        hh = (hh + off + 360) % 360;
      end
      o.hue = 9'(hh);
    end else begin
      hh = (p.hue >= 360) ? 0 : p.hue;
      sector = hh / 60;
      f = hh % 60;
      kx = (sector % 2 == 0) ? f : 60 - f;
      case (sector)
        0: k = '{60, kx, 0};
        1: k = '{kx, 60, 0};
        2: k = '{0, 60, kx};
        3: k = '{0, kx, 60};
        4: k = '{kx, 0, 60};
        default: k = '{60, 0, kx};
      endcase
      o.red   = 8'((15300 * p.val - p.val * p.sat * (60 - k[0])) / 15300);
      o.green = 8'((15300 * p.val - p.val * p.sat * (60 - k[1])) / 15300);
      o.blue  = 8'((15300 * p.val - p.val * p.sat * (60 - k[2])) / 15300);
      o.hue   = 9'(hh);
    end
    return o;
  endfunction

  function automatic pixel_t mk(int r, int g, int b, int h, int s, int v);
    pixel_t p;
    p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b);
    p.hue = 9'(h); p.sat = 8'(s); p.val = 8'(v);
    return p;
  endfunction

  task automatic send_pixel(logic mode, pixel_t p, bit may_idle);
    while (may_idle && !calm && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= 56'(p);
    pixel_queue.push_back(convert_pixel(mode, p));
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // receiver with random stall
  always @(negedge clk_i)
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 10);

  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pixel_t'(m_axis_tdata[48:0]);
      if (pixel_queue.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pixel_queue.pop_front();
        if (got.red !== want.red) begin
          $error("out_red expected %0d got %0d", want.red, got.red); fail_count++;
        end
        if (got.green !== want.green) begin
          $error("out_green expected %0d got %0d", want.green, got.green); fail_count++;
        end
        if (got.blue !== want.blue) begin
          $error("out_blue expected %0d got %0d", want.blue, got.blue); fail_count++;
        end
        if (got.hue !== want.hue) begin
          $error("out_hue expected %0d got %0d", want.hue, got.hue); fail_count++;
        end
        if (got.sat !== want.sat) begin
          $error("out_sat expected %0d got %0d", want.sat, got.sat); fail_count++;
        end
        if (got.val !== want.val) begin
          $error("out_val expected %0d got %0d", want.val, got.val); fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG) timed_out <= 1'b1;
  end

  initial begin
    row_t rows[$];
    pixel_t p, pk;
    logic mode;
    int unsigned n;
    rows = '{
      '{MODE_TO_HSV, mk(0, 0, 0, 0, 0, 0), 1'b1, mk(0, 0, 0, 0, 0, 0)},
      '{MODE_TO_HSV, mk(255, 255, 255, 0, 0, 0), 1'b1, mk(255, 255, 255, 0, 0, 255)},
      '{MODE_TO_HSV, mk(255, 0, 0, 0, 0, 0), 1'b1, mk(255, 0, 0, 0, 255, 255)},
      '{MODE_TO_HSV, mk(0, 255, 0, 0, 0, 0), 1'b1, mk(0, 255, 0, 120, 255, 255)},
      '{MODE_TO_HSV, mk(0, 0, 255, 0, 0, 0), 1'b1, mk(0, 0, 255, 240, 255, 255)},
      '{MODE_TO_HSV, mk(255, 0, 1, 511, 255, 255), 1'b0, '0},
      '{MODE_TO_HSV, mk(1, 255, 0, 0, 0, 0), 1'b0, '0},
      '{MODE_TO_HSV, mk(0, 1, 255, 0, 0, 0), 1'b0, '0},
      '{MODE_TO_HSV, mk(128, 128, 64, 0, 0, 0), 1'b0, '0},
      '{MODE_TO_HSV, mk(7, 7, 7, 0, 0, 0), 1'b0, '0},
      '{MODE_TO_RGB, mk(0, 0, 0, 0, 0, 0), 1'b1, mk(0, 0, 0, 0, 0, 0)},
      '{MODE_TO_RGB, mk(0, 0, 0, 0, 255, 255), 1'b1, mk(255, 0, 0, 0, 255, 255)},
      '{MODE_TO_RGB, mk(0, 0, 0, 120, 255, 255), 1'b1, mk(0, 255, 0, 120, 255, 255)},
      '{MODE_TO_RGB, mk(0, 0, 0, 240, 255, 255), 1'b1, mk(0, 0, 255, 240, 255, 255)},
      '{MODE_TO_RGB, mk(0, 0, 0, 360, 255, 255), 1'b1, mk(255, 0, 0, 0, 255, 255)},
      '{MODE_TO_RGB, mk(255, 255, 255, 511, 255, 255), 1'b1, mk(255, 0, 0, 0, 255, 255)},
      '{MODE_TO_RGB, mk(0, 0, 0, 359, 255, 255), 1'b0, '0},
      '{MODE_TO_RGB, mk(0, 0, 0, 60, 128, 200), 1'b0, '0},
      '{MODE_TO_RGB, mk(0, 0, 0, 90, 255, 255), 1'b0, '0},
      '{MODE_TO_RGB, mk(0, 0, 0, 210, 100, 255), 1'b0, '0},
      '{MODE_TO_RGB, mk(0, 0, 0, 300, 255, 1), 1'b0, '0},
      '{MODE_TO_RGB, mk(0, 0, 0, 330, 0, 255), 1'b0, '0}
    };
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    fork
      begin
        foreach (rows[i]) begin
          send_pixel(rows[i].mode, rows[i].pix, 1'b1);
          // pin the typed-in results onto the queued expectation
          if (rows[i].known) pixel_queue[$] = rows[i].res;
        end
        s_axis_tvalid <= 1'b0;
        // drain fully before the random part
        wait (pixel_queue.size() == 0);
        @(negedge clk_i);
        for (n = 0; n < N_RANDOM; n++) begin
          calm = (n >= 300 && n < 450);
          mode = 1'($urandom_range(1));
          p = pixel_t'(49'({$urandom, $urandom}));
          if (n % 4 == 0) p.hue = 9'($urandom_range(359));
          if (n % 16 == 1) begin
            pk = p; p.green = pk.red; p.blue = pk.red;
          end
          send_pixel(mode, p, 1'b1);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        wait (pixel_queue.size() == 0);
        repeat (LATENCY + 4) @(posedge clk_i);
      end
      wait (timed_out);
    join_any

    if (timed_out) begin
      $display("CHECKS FAILED");
    end else if (fail_count == 0 && pixel_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/rhc_pkg.sv
hdl/rhc_front.sv
hdl/rhc_div.sv
hdl/rgb_hsv_converter.sv
tb/sv/rgb_hsv_converter_tb.sv
